// File: rtl/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg: shared definitions for the serial ring and block buffer
// Field widths, default depths, operation codes and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package urb_pkg;

    localparam int FUNC_W       = 3;
    localparam int BYTE_W       = 8;
    localparam int BLEN_W       = 7;
    localparam int TX_DEPTH_DEF = 256;
    localparam int RX_DEPTH_DEF = 64;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FN_HOST_WR = 3'd0;
    localparam t_func FN_TX_SLOT = 3'd1;
    localparam t_func FN_RX_BYTE = 3'd2;
    localparam t_func FN_RX_TMO  = 3'd3;
    localparam t_func FN_RD_BLK  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic emit;
        logic blk_rd;
        logic blk_emit;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic blk_start;
        logic blk_last;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/urb_ram.sv
// ----------------------------------------------------------------------------
// urb_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module urb_ram #(
    parameter int  W  = 8,
    parameter int  D  = 256,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/urb_datapath.sv
// ----------------------------------------------------------------------------
// urb_datapath: ring pointers, block counters, memories and output register
// Carries out the operation of each captured item on command and holds the
// result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module urb_datapath import urb_pkg::*; #(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_accepted,
    output logic [BYTE_W-1:0] o_tx_byte,
    output logic              o_tx_valid,
    output logic              o_tx_request,
    output logic [BYTE_W-1:0] o_rx_byte,
    output logic              o_rx_valid,
    output logic              o_last,
    output logic [BLEN_W-1:0] o_block_len
);

    localparam int PW  = $clog2(TX_DEPTH);
    localparam int RXA = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RXC = $clog2(RX_DEPTH + 1);

    // Captured item.
    t_func             r_func;
    logic [BYTE_W-1:0] r_data;

    // Ring and block state.
    logic [PW-1:0]  r_head, n_head, r_tail, n_tail;
    logic           r_irq, n_irq;
    logic [RXC-1:0] r_rx_count, n_rx_count, r_ready_len, n_ready_len;
    logic [RXC-1:0] r_blk_n;
    logic [RXA-1:0] r_idx;

    // Result staging for single-beat items.
    logic              r_stg_acc, n_stg_acc, r_stg_txv, n_stg_txv;
    logic [BLEN_W-1:0] r_stg_blen, n_stg_blen;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic              r_out_acc, r_out_txv, r_out_req, r_out_rxv, r_out_last;
    logic [BYTE_W-1:0] r_out_txb, r_out_rxb;
    logic [BLEN_W-1:0] r_out_blen;

    logic [PW-1:0]     head_inc, tail_inc;
    logic              tx_full, tx_empty, tx_we, tx_re, rx_we;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    assign head_inc = (r_head == PW'(TX_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign tail_inc = (r_tail == PW'(TX_DEPTH - 1)) ? '0 : r_tail + PW'(1);
    assign tx_full  = (head_inc == r_tail);
    assign tx_empty = (r_head == r_tail);

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_irq       = r_irq;
        n_rx_count  = r_rx_count;
        n_ready_len = r_ready_len;
        n_stg_acc   = 1'b0;
        n_stg_txv   = 1'b0;
        n_stg_blen  = BLEN_W'(r_ready_len);
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        rx_we       = 1'b0;
        if (i_cmd.execute) begin
            case (r_func)
                FN_HOST_WR: begin
                    n_irq = 1'b1;
                    if (!tx_full) begin
                        tx_we     = 1'b1;
                        n_head    = head_inc;
                        n_stg_acc = 1'b1;
                    end
                end
                FN_TX_SLOT: begin
                    if (tx_empty) begin
                        n_irq = 1'b0;
                    end else begin
                        tx_re     = 1'b1;
                        n_tail    = tail_inc;
                        n_stg_txv = 1'b1;
                    end
                end
                FN_RX_BYTE: begin
                    if (r_ready_len == '0 && r_rx_count < RXC'(RX_DEPTH)) begin
                        rx_we      = 1'b1;
                        n_rx_count = r_rx_count + RXC'(1);
                        if (n_rx_count == RXC'(RX_DEPTH)) begin
                            n_ready_len = n_rx_count;
                        end
                    end
                    n_stg_blen = BLEN_W'(n_ready_len);
                end
                FN_RX_TMO: begin
                    n_ready_len = r_rx_count;
                    n_stg_blen  = BLEN_W'(r_rx_count);
                end
                FN_RD_BLK: begin
                    n_rx_count  = '0;
                    n_ready_len = '0;
                    n_stg_blen  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.blk_start = (r_func == FN_RD_BLK) && (r_ready_len != '0);
    assign o_stat.blk_last  = ((RXC'(r_idx) + RXC'(1)) == r_blk_n);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit || i_cmd.blk_emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_irq       <= 1'b0;
            r_rx_count  <= '0;
            r_ready_len <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_irq       <= n_irq;
            r_rx_count  <= n_rx_count;
            r_ready_len <= n_ready_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_data <= i_data;
        end
        if (i_cmd.execute) begin
            r_stg_acc  <= n_stg_acc;
            r_stg_txv  <= n_stg_txv;
            r_stg_blen <= n_stg_blen;
            r_blk_n    <= r_ready_len;
            r_idx      <= '0;
        end
        if (i_cmd.blk_emit) begin
            r_idx <= r_idx + RXA'(1);
        end
        if (i_cmd.emit) begin
            r_out_acc  <= r_stg_acc;
            r_out_txv  <= r_stg_txv;
            r_out_txb  <= r_stg_txv ? tx_rdata : '0;
            r_out_req  <= r_irq;
            r_out_rxv  <= 1'b0;
            r_out_rxb  <= '0;
            r_out_last <= 1'b1;
            r_out_blen <= r_stg_blen;
        end else if (i_cmd.blk_emit) begin
            r_out_acc  <= 1'b0;
            r_out_txv  <= 1'b0;
            r_out_txb  <= '0;
            r_out_req  <= r_irq;
            r_out_rxv  <= 1'b1;
            r_out_rxb  <= rx_rdata;
            r_out_last <= o_stat.blk_last;
            r_out_blen <= BLEN_W'(r_blk_n);
        end
    end

    urb_ram #(.W(BYTE_W), .D(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_head),
        .i_wdata (r_data),
        .i_re    (tx_re),
        .i_raddr (r_tail),
        .o_rdata (tx_rdata)
    );

    urb_ram #(.W(BYTE_W), .D(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_count[RXA-1:0]),
        .i_wdata (r_data),
        .i_re    (i_cmd.blk_rd),
        .i_raddr (r_idx),
        .o_rdata (rx_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_out_acc;
    assign o_tx_byte    = r_out_txb;
    assign o_tx_valid   = r_out_txv;
    assign o_tx_request = r_out_req;
    assign o_rx_byte    = r_out_rxb;
    assign o_rx_valid   = r_out_rxv;
    assign o_last       = r_out_last;
    assign o_block_len  = r_out_blen;

endmodule

// File: rtl/urb_ctrl.sv
// ----------------------------------------------------------------------------
// urb_ctrl: sequencing state machine
// Takes one item, has the datapath execute it, then emits one result beat or
// walks the received block one byte at a time.
// ----------------------------------------------------------------------------
module urb_ctrl import urb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_EMIT  = 5'b00100,
        S_BRD   = 5'b01000,
        S_BEMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = i_stat.blk_start ? S_BRD : S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_BRD: begin
                o_cmd.blk_rd = 1'b1;
                n_state      = S_BEMIT;
            end
            S_BEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.blk_emit = 1'b1;
                    n_state        = i_stat.blk_last ? S_IDLE : S_BRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: rtl/uart_ring_and_block_buffer.sv
// An item passes the capture and execute states; its beat enters the output register
// from the emit state, which waits while the output stalls. No new item is taken until
// the last is through; a block read alternates a read and an emit state per byte, as the
// store's read is registered. Reset (synchronous, active low) empties the ring, drops any
// block and clears the request; it clears neither store, so items are taken at once.
// ----------------------------------------------------------------------------
// uart_ring_and_block_buffer: transmit ring and receive block buffer
// Host bytes queue in a ring for the transmitter; received bytes collect in a
// block store that is handed to the host as a burst of beats.
// ----------------------------------------------------------------------------
module uart_ring_and_block_buffer import urb_pkg::*; #(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input channel: one beat is one item.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [BYTE_W-1:0] i_data,
    // Output channel: one beat is one result.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_accepted,
    output logic [BYTE_W-1:0] o_tx_byte,
    output logic              o_tx_valid,
    output logic              o_tx_request,
    output logic [BYTE_W-1:0] o_rx_byte,
    output logic              o_rx_valid,
    output logic              o_last,
    output logic [BLEN_W-1:0] o_block_len
);

    // The controller sequences each item; the datapath owns every other piece of
    // state, both memories and the output register. The output register lets
    // a new item be taken while a finished beat still waits downstream.
    t_cmd  cmd;
    t_stat stat;

    urb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The transmit ring keeps one slot open so that full and empty differ,
    // which is why it holds at most TX_DEPTH-1 bytes. The block store fills
    // from address zero and closes when full or on a receive timeout.
    urb_datapath #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_data       (i_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_accepted   (o_accepted),
        .o_tx_byte    (o_tx_byte),
        .o_tx_valid   (o_tx_valid),
        .o_tx_request (o_tx_request),
        .o_rx_byte    (o_rx_byte),
        .o_rx_valid   (o_rx_valid),
        .o_last       (o_last),
        .o_block_len  (o_block_len)
    );

endmodule

// File: rtl/urb_checker.sv
// ----------------------------------------------------------------------------
// urb_checker: port-level checks for the serial ring and block buffer
// Watches the top-level ports and flags broken handshakes or result beats
// whose fields contradict each other.
// ----------------------------------------------------------------------------
module urb_checker import urb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_accepted,
    input logic [BYTE_W-1:0] o_tx_byte,
    input logic              o_tx_valid,
    input logic              o_tx_request,
    input logic [BYTE_W-1:0] o_rx_byte,
    input logic              o_rx_valid,
    input logic              o_last,
    input logic [BLEN_W-1:0] o_block_len
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tx_byte)
            && $stable(o_rx_byte) && $stable(o_block_len) && $stable(o_last))
        else $error("result beat changed while stalled");

    // An accepted host byte comes alone and ends its item.
    a_acc_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> !o_tx_valid && !o_rx_valid && o_last
            && o_tx_request)
        else $error("accepted beat carries other data");

    // A block byte belongs to a block of nonzero length.
    a_blk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rx_valid |-> o_block_len != '0 && !o_tx_valid)
        else $error("block byte without block length");

    // Every item other than a block read ends in its single beat.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rx_valid |-> o_last)
        else $error("single-beat result without last");

    // Reset empties the output side.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

endmodule

bind uart_ring_and_block_buffer urb_checker u_urb_checker (.*);

// File: verif/tb_uart_ring_and_block_buffer.sv
// ----------------------------------------------------------------------------
// tb_uart_ring_and_block_buffer: self-checking bench for the ring and block buffer
// A table of directed items walks the corner cases of the transmit ring and
// the receive block store. Shaped random traffic follows under four idling
// mixes. Every result beat is checked against a behavioral predictor or a typed value.
// ----------------------------------------------------------------------------
module tb_uart_ring_and_block_buffer;
    import urb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Depths of the instance below, which keeps the package defaults.
    localparam int RING_N = TX_DEPTH_DEF;
    localparam int BLK_N  = RX_DEPTH_DEF;

    // The block ignores these operation codes. It still answers each of them
    // with one beat.
    localparam t_func FN_SPARE5 = 3'd5;
    localparam t_func FN_SPARE6 = 3'd6;
    localparam t_func FN_SPARE7 = 3'd7;

    // The watchdog ends the run after this many cycles in a row in which
    // neither channel moves a beat. The slowest correct stretch is the
    // deliberate receiver hold-off. Random stalls add little to it, so the
    // margin is wide.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_ITEMS   = 128;

    // One result beat, laid out field by field as on the output ports.
    typedef struct packed {
        logic              accepted;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_valid;
        logic              tx_request;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_valid;
        logic              last;
        logic [BLEN_W-1:0] block_len;
    } buf_result_t;

    // One row of the directed table. A row can repeat its operation. On each
    // repeat the data byte goes up by one. Rows with a typed expectation cause
    // exactly one beat, and that beat is checked against the typed value
    // instead of the predicted one.
    typedef struct {
        t_func             op;
        logic [BYTE_W-1:0] dat;
        int                reps;
        bit                typed;
        buf_result_t       want;
    } stim_row_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [FUNC_W-1:0] i_func;
    logic [BYTE_W-1:0] i_data;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_accepted;
    logic [BYTE_W-1:0] o_tx_byte;
    logic              o_tx_valid;
    logic              o_tx_request;
    logic [BYTE_W-1:0] o_rx_byte;
    logic              o_rx_valid;
    logic              o_last;
    logic [BLEN_W-1:0] o_block_len;

    // Predictor state: the transmit ring with its pointers and request flag,
    // and the receive block store with its fill count and closed length.
    logic [BYTE_W-1:0] ring_mem [RING_N];
    int                ring_wr;
    int                ring_rd;
    logic              tx_req;
    logic [BYTE_W-1:0] blk_mem [BLK_N];
    int                blk_fill;
    int                blk_ready;

    // Beats the block still owes, oldest first.
    buf_result_t       due_beats [$];
    stim_row_t         dir_rows [$];

    int                errors;
    int                beats_sent;
    int                idle_pct;
    int                stall_pct;
    int                idle_run;
    int                hold_asked;
    int                hold_done;
    int                hold_left;

    uart_ring_and_block_buffer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_data       (i_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_accepted   (o_accepted),
        .o_tx_byte    (o_tx_byte),
        .o_tx_valid   (o_tx_valid),
        .o_tx_request (o_tx_request),
        .o_rx_byte    (o_rx_byte),
        .o_rx_valid   (o_rx_valid),
        .o_last       (o_last),
        .o_block_len  (o_block_len)
    );

    // 20 ns clock period.
    always #10 i_clk = ~i_clk;

    // Works out the beats that one accepted item causes. It appends them to
    // the queue of beats due and updates the predictor state.
    function automatic void predict_item(t_func op, logic [BYTE_W-1:0] dat);
        buf_result_t r;
        int          nxt;
        int          n;
        int          i;
        r      = '0;
        r.last = 1'b1;
        case (op)
            FN_HOST_WR: begin
                // One slot always stays empty, so the ring holds at most
                // RING_N-1 bytes. The request goes up even when the ring
                // refuses the byte.
                nxt = (ring_wr + 1) % RING_N;
                if (nxt != ring_rd) begin
                    ring_mem[ring_wr] = dat;
                    ring_wr           = nxt;
                    r.accepted        = 1'b1;
                end
                tx_req = 1'b1;
            end
            FN_TX_SLOT: begin
                // An empty ring answers a free slot by dropping the request.
                if (ring_wr == ring_rd) begin
                    tx_req = 1'b0;
                end else begin
                    r.tx_byte  = ring_mem[ring_rd];
                    r.tx_valid = 1'b1;
                    ring_rd    = (ring_rd + 1) % RING_N;
                end
            end
            FN_RX_BYTE: begin
                // While a block is pending, a received byte is dropped.
                if (blk_ready == 0 && blk_fill < BLK_N) begin
                    blk_mem[blk_fill] = dat;
                    blk_fill++;
                    if (blk_fill == BLK_N) begin
                        blk_ready = blk_fill;
                    end
                end
            end
            FN_RX_TMO: begin
                // With no bytes this leaves the length at zero. With a block
                // already pending, the fill count equals the length.
                blk_ready = blk_fill;
            end
            FN_RD_BLK: begin
                // A read always empties the store. Partial bytes with no
                // closed block are lost.
                n         = blk_ready;
                blk_fill  = 0;
                blk_ready = 0;
                for (i = 0; i < n; i++) begin
                    r            = '0;
                    r.tx_request = tx_req;
                    r.rx_byte    = blk_mem[i];
                    r.rx_valid   = 1'b1;
                    r.last       = (i == n - 1);
                    r.block_len  = n[BLEN_W-1:0];
                    due_beats.push_back(r);
                end
                if (n > 0) begin
                    return;
                end
            end
            default: begin
            end
        endcase
        r.tx_request = tx_req;
        r.block_len  = blk_ready[BLEN_W-1:0];
        due_beats.push_back(r);
    endfunction

    function automatic buf_result_t res_of(logic acc, logic [BYTE_W-1:0] txb,
                                           logic txv, logic req,
                                           logic [BYTE_W-1:0] rxb, logic rxv,
                                           logic lst, logic [BLEN_W-1:0] blen);
        buf_result_t r;
        r = '{acc, txb, txv, req, rxb, rxv, lst, blen};
        return r;
    endfunction

    function automatic stim_row_t row(t_func op, logic [BYTE_W-1:0] dat, int reps = 1);
        stim_row_t s;
        s = '{op, dat, reps, 1'b0, '0};
        return s;
    endfunction

    function automatic stim_row_t trow(t_func op, logic [BYTE_W-1:0] dat,
                                       buf_result_t want);
        stim_row_t s;
        s = '{op, dat, 1, 1'b1, want};
        return s;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Offers one item and waits until the block takes it. The item is
    // predicted at the edge that accepts it. If a typed expectation is given,
    // it replaces the single predicted beat. Entry and exit are just after a
    // falling edge. Valid stays high into the next item unless a gap is drawn,
    // so valid gets at most one assignment per edge.
    task automatic send_beat(t_func op, logic [BYTE_W-1:0] dat,
                             bit typed = 1'b0, buf_result_t want = '0);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_data     <= dat;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        predict_item(op, dat);
        if (typed) begin
            due_beats[due_beats.size() - 1] = want;
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Shaped random traffic. Most of it is well-formed bursts: runs of host
    // writes, runs of transmit slots, and received blocks that close and are
    // read back. Single items with any operation code, the unused ones among
    // them, are mixed in as noise. A burst ends early when the item budget
    // of the call runs out.
    task automatic random_traffic(int n_items);
        int stop_at;
        int kind;
        int k;
        int i;
        stop_at = beats_sent + n_items;
        while (beats_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                // A rare long write burst runs into a full ring.
                k = ($urandom_range(24) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 12);
                for (i = 0; i < k && beats_sent < stop_at; i++) begin
                    send_beat(FN_HOST_WR, rand_byte());
                end
            end else if (kind < 45) begin
                k = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
                for (i = 0; i < k && beats_sent < stop_at; i++) begin
                    send_beat(FN_TX_SLOT, rand_byte());
                end
            end else if (kind < 75) begin
                // A received block: some bytes, usually a timeout, sometimes a late byte
                // that is dropped if the block is pending, and mostly then the read.
                k = ($urandom_range(7) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
                for (i = 0; i < k && beats_sent < stop_at; i++) begin
                    send_beat(FN_RX_BYTE, rand_byte());
                end
                if ($urandom_range(4) != 0) begin
                    send_beat(FN_RX_TMO, rand_byte());
                end
                if ($urandom_range(3) == 0) begin
                    send_beat(FN_RX_BYTE, rand_byte());
                end
                if ($urandom_range(9) != 0) begin
                    send_beat(FN_RD_BLK, rand_byte());
                end
            end else if (kind < 85) begin
                send_beat(FN_RD_BLK, rand_byte());
            end else begin
                send_beat(t_func'($urandom_range(7)), rand_byte());
            end
        end
    endtask

    // The receiver side drives stall at the falling edge. A hold-off asked
    // for by the main sequence is counted out here. During the hold-off the
    // sender keeps offering items, so the block fills and stalls its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_asked != hold_done) begin
            hold_done   <= hold_asked;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Result checking at the rising edge. The block updates its outputs
    // through registers, so the values seen here are the ones from before
    // the edge.
    always @(posedge i_clk) begin : result_check
        buf_result_t want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (due_beats.size() == 0) begin
                $error("result beat arrived with no expectation pending");
                errors++;
            end else begin
                want = due_beats.pop_front();
                check_field("accepted",   want.accepted,   o_accepted);
                check_field("tx_byte",    want.tx_byte,    o_tx_byte);
                check_field("tx_valid",   want.tx_valid,   o_tx_valid);
                check_field("tx_request", want.tx_request, o_tx_request);
                check_field("rx_byte",    want.rx_byte,    o_rx_byte);
                check_field("rx_valid",   want.rx_valid,   o_rx_valid);
                check_field("last",       want.last,       o_last);
                check_field("block_len",  want.block_len,  o_block_len);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_run <= 0;
        end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin : main_seq
        int idle_mix [4];
        int stall_mix [4];
        int p;
        int r;
        int k;

        idle_mix  = '{0, 45, 0, 28};
        stall_mix = '{0, 0, 45, 28};

        // Every input has a known value from time zero.
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FN_HOST_WR;
        i_data      = '0;
        i_out_stall = 1'b0;
        errors      = 0;
        beats_sent  = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        idle_run    = 0;
        hold_asked  = 0;
        hold_done   = 0;
        hold_left   = 0;
        ring_wr     = 0;
        ring_rd     = 0;
        tx_req      = 1'b0;
        blk_fill    = 0;
        blk_ready   = 0;

        // The directed table. After reset, a read with nothing pending and a
        // free slot with an empty ring give one plain beat each. The next rows
        // cover both data extremes through the ring, a timeout with no bytes,
        // a short block, a byte and a timeout while the block is pending, the
        // unused codes, and partial bytes lost on a read. The last rows fill
        // the ring to its refusal point and leave it full for the random
        // part, and fill the block store until it closes by itself, so the
        // longest read of the block follows.
        dir_rows.push_back(trow(FN_RD_BLK,  8'h00, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_TX_SLOT, 8'hFF, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_HOST_WR, 8'h00, res_of(1, 8'h00, 0, 1, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_HOST_WR, 8'hFF, res_of(1, 8'h00, 0, 1, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_TX_SLOT, 8'h00, res_of(0, 8'h00, 1, 1, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_TX_SLOT, 8'h00, res_of(0, 8'hFF, 1, 1, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_TX_SLOT, 8'h00, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_RX_TMO,  8'hFF, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_RX_BYTE, 8'hA5, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(row(FN_RX_BYTE,  8'h5A));
        dir_rows.push_back(row(FN_RX_BYTE,  8'hFF));
        dir_rows.push_back(trow(FN_RX_TMO,  8'h00, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 3)));
        dir_rows.push_back(trow(FN_RX_BYTE, 8'h33, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 3)));
        dir_rows.push_back(trow(FN_RX_TMO,  8'h00, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 3)));
        dir_rows.push_back(row(FN_RD_BLK,   8'h00));
        dir_rows.push_back(trow(FN_SPARE5,  8'hFF, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_SPARE6,  8'h81, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_SPARE7,  8'h7E, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_RX_BYTE, 8'h00, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(trow(FN_RD_BLK,  8'h00, res_of(0, 8'h00, 0, 0, 8'h00, 0, 1, 0)));
        dir_rows.push_back(row(FN_HOST_WR,  8'h10, RING_N - 1));
        dir_rows.push_back(trow(FN_HOST_WR, 8'hC3, res_of(0, 8'h00, 0, 1, 8'h00, 0, 1, 0)));
        dir_rows.push_back(row(FN_RX_BYTE,  8'h80, BLK_N));
        dir_rows.push_back(trow(FN_RX_BYTE, 8'h7F,
                                res_of(0, 8'h00, 0, 1, 8'h00, 0, 1, BLEN_W'(BLK_N))));
        dir_rows.push_back(row(FN_RD_BLK,   8'h00));

        // Reset is held low once and released at a falling edge.
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The directed part runs with light idling on both sides.
        idle_pct  = 28;
        stall_pct = 28;
        for (r = 0; r < dir_rows.size(); r++) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                send_beat(dir_rows[r].op, dir_rows[r].dat + k[BYTE_W-1:0],
                          dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // The random part runs in four idling mixes. The first mix, with no
        // idling, starts with the long receiver hold-off.
        for (p = 0; p < 4; p++) begin
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            if (p == 0) begin
                hold_asked = hold_asked + 1;
            end
            random_traffic(RANDOM_ITEMS / 4);
        end
        i_in_valid <= 1'b0;

        // Drain: every beat due must arrive. Then a quiet tail shows that
        // no extra beat follows.
        while (due_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/urb_pkg.sv
rtl/urb_ram.sv
rtl/urb_datapath.sv
rtl/urb_ctrl.sv
rtl/uart_ring_and_block_buffer.sv
rtl/urb_checker.sv
verif/tb_uart_ring_and_block_buffer.sv
